// ===== rtl/gmd_pkg.sv =====
// Types and constants shared by the Gaussian mixture density block.
package gmd_pkg;

    localparam int NUM_COMP_REGS = 4;
    localparam int TAYLOR_TERMS  = 13;

    // register indexes
    localparam logic [2:0] REG_COMP_0 = 3'd0;
    localparam logic [2:0] REG_COUNT  = 3'd4;

    localparam logic [63:0] COMP_RESET = 64'h0100_0100_0000_0000;
    localparam logic [31:0] LOG2E_Q30  = 32'd1549082005;
    localparam logic [31:0] LN2_Q32    = 32'd2977044472;
    localparam logic [31:0] INV2PI_Q32 = 32'd683565276;
    localparam logic [40:0] EXP_LIMIT  = 41'd4194304;

    // shared divider geometry
    localparam int DIV_NW = 40;
    localparam int DIV_DW = 25;
    // square root geometry
    localparam int SQRT_IW = 48;
    localparam int SQRT_RW = 24;

    typedef struct packed {
        logic [15:0]        var_y;
        logic [15:0]        var_x;
        logic signed [15:0] mean_y;
        logic signed [15:0] mean_x;
    } comp_t;

endpackage

// ===== rtl/gmd_if.sv =====
// Stream interfaces for points in and densities out.
interface gmd_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;

    modport source (output valid, output pos_x, output pos_y, input ready);
    modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

interface gmd_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] density;

    modport source (output valid, output density, input ready);
    modport sink   (input valid, input density, output ready);
endinterface

// ===== rtl/gmd_div.sv =====
// Restoring divider, one quotient bit per cycle.
module gmd_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [gmd_pkg::DIV_NW-1:0]    dividend,
    input  logic [gmd_pkg::DIV_DW-1:0]    divisor,
    output logic                          done,
    output logic [gmd_pkg::DIV_NW-1:0]    quotient
);
    localparam int NW = gmd_pkg::DIV_NW;
    localparam int DW = gmd_pkg::DIV_DW;
    localparam int CW = $clog2(NW);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] dvs_reg;
    logic [NW-1:0] quo_reg;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] rem_next;

    assign shifted  = {rem_reg, quo_reg[NW-1]};
    assign ge       = shifted >= {1'b0, dvs_reg};
    assign diff     = shifted - {1'b0, dvs_reg};
    assign rem_next = ge ? diff[DW-1:0] : shifted[DW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CW'(1);
            if (cnt_reg == CW'(NW - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[NW-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

// ===== rtl/gmd_sqrt.sv =====
// Integer square root, one root bit per cycle.
module gmd_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [gmd_pkg::SQRT_IW-1:0]   radicand,
    output logic                          done,
    output logic [gmd_pkg::SQRT_RW-1:0]   root
);
    localparam int IW = gmd_pkg::SQRT_IW;
    localparam int RW = gmd_pkg::SQRT_RW;
    localparam int CW = $clog2(RW);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [IW-1:0] rad_reg;
    logic [RW+1:0] rem_reg;
    logic [RW-1:0] root_reg;
    logic [RW+3:0] shifted;
    logic [RW+3:0] trial;
    logic [RW+3:0] diff;
    logic          ge;

    assign shifted = {rem_reg, rad_reg[IW-1:IW-2]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign ge      = shifted >= trial;
    assign diff    = shifted - trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CW'(1);
            if (cnt_reg == CW'(RW - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[IW-3:0], 2'b00};
            rem_reg  <= ge ? diff[RW+1:0] : shifted[RW+1:0];
            root_reg <= {root_reg[RW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

// ===== rtl/gaussian_mixture_density_2d_top.sv =====
// Gaussian mixture density top level: sequencer, shared multiplier and registers.
// Each component in use takes two quotients on the shared divider, 13 Taylor steps
// and one final divide; a component whose exponent is out of range stops after the
// two quotients. The block takes one point at a time; the next point is accepted
// once the result is queued.
// Reset: components return to mean 0, variance 1.0, one component in use; no result held.
module gaussian_mixture_density_2d_top #(
    parameter int MAX_COMPONENTS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    gmd_in_if.sink      in_ch,
    gmd_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    localparam int KW = $clog2(MAX_COMPONENTS + 1);
    localparam int IW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
    localparam logic [2:0] MAX_C = 3'(MAX_COMPONENTS);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_LOAD  = 5'd1;
    localparam logic [4:0] ST_SQX   = 5'd2;
    localparam logic [4:0] ST_DXGO  = 5'd3;
    localparam logic [4:0] ST_DXW   = 5'd4;
    localparam logic [4:0] ST_SQY   = 5'd5;
    localparam logic [4:0] ST_DYGO  = 5'd6;
    localparam logic [4:0] ST_DYW   = 5'd7;
    localparam logic [4:0] ST_CHK   = 5'd8;
    localparam logic [4:0] ST_YST   = 5'd9;
    localparam logic [4:0] ST_USET  = 5'd10;
    localparam logic [4:0] ST_TMUL  = 5'd11;
    localparam logic [4:0] ST_TDIV  = 5'd12;
    localparam logic [4:0] ST_TW    = 5'd13;
    localparam logic [4:0] ST_SQV   = 5'd14;
    localparam logic [4:0] ST_SQGO  = 5'd15;
    localparam logic [4:0] ST_SQW   = 5'd16;
    localparam logic [4:0] ST_EMUL  = 5'd17;
    localparam logic [4:0] ST_FDIV  = 5'd18;
    localparam logic [4:0] ST_FW    = 5'd19;
    localparam logic [4:0] ST_NEXT  = 5'd20;
    localparam logic [4:0] ST_DONE  = 5'd21;

    logic [63:0]        comp_reg [MAX_COMPONENTS];
    logic [2:0]         count_reg;
    logic [4:0]         state_reg;
    logic [KW-1:0]      k_reg;
    logic [KW-1:0]      kmax_reg;
    logic signed [15:0] x_reg;
    logic signed [15:0] y_reg;
    logic [15:0]        vx_reg;
    logic [15:0]        vy_reg;
    logic [15:0]        ax_reg;
    logic [15:0]        ay_reg;
    logic [40:0]        t_reg;
    logic [5:0]         n_reg;
    logic [31:0]        u_reg;
    logic [32:0]        term_reg;
    logic [32:0]        esum_reg;
    logic [3:0]         j_reg;
    logic [23:0]        s_reg;
    logic [33:0]        acc_reg;
    logic [64:0]        prod_reg;
    logic               out_valid_reg;
    logic [31:0]        density_reg;

    logic [2:0]         cfg_idx;
    logic               cfg_wr;
    logic [2:0]         count_clamp;
    gmd_pkg::comp_t     comp_sel;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic [16:0]        adx;
    logic [16:0]        ady;
    logic [32:0]        mul_a;
    logic [31:0]        mul_b;
    logic [32:0]        e_val;
    logic [32:0]        tq;

    logic                          div_start;
    logic [gmd_pkg::DIV_NW-1:0]    div_num;
    logic [gmd_pkg::DIV_DW-1:0]    div_den;
    logic                          div_done;
    logic [gmd_pkg::DIV_NW-1:0]    div_quo;
    logic                          sqrt_start;
    logic                          sqrt_done;
    logic [gmd_pkg::SQRT_RW-1:0]   sqrt_root;

    // configuration port
    assign cfg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_COMPONENTS; i++)
            begin
                comp_reg[i] <= gmd_pkg::COMP_RESET;
            end
            count_reg <= 3'd1;
        end
        else if (cfg_wr)
        begin
            for (int i = 0; i < MAX_COMPONENTS; i++)
            begin
                if (i < gmd_pkg::NUM_COMP_REGS && cfg_idx == gmd_pkg::REG_COMP_0 + 3'(i))
                begin
                    comp_reg[i] <= pwdata;
                end
            end
            if (cfg_idx == gmd_pkg::REG_COUNT)
            begin
                count_reg <= pwdata[2:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        for (int i = 0; i < MAX_COMPONENTS; i++)
        begin
            if (i < gmd_pkg::NUM_COMP_REGS && cfg_idx == gmd_pkg::REG_COMP_0 + 3'(i))
            begin
                prdata = comp_reg[i];
            end
        end
        if (cfg_idx == gmd_pkg::REG_COUNT)
        begin
            prdata = {61'd0, count_reg};
        end
    end

    assign count_clamp = (count_reg == 3'd0) ? 3'd1 :
                         (count_reg > MAX_C) ? MAX_C : count_reg;

    // per-component operands
    assign comp_sel = gmd_pkg::comp_t'(comp_reg[k_reg[IW-1:0]]);
    assign dx  = 17'(x_reg) - 17'(comp_sel.mean_x);
    assign dy  = 17'(y_reg) - 17'(comp_sel.mean_y);
    assign adx = dx[16] ? 17'(-dx) : 17'(dx);
    assign ady = dy[16] ? 17'(-dy) : 17'(dy);

    assign e_val = (n_reg >= 6'd33) ? 33'd0 : (esum_reg >> n_reg);
    assign tq    = div_quo[32:0];

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            ST_SQX:  begin mul_a = 33'(ax_reg);           mul_b = 32'(ax_reg);        end
            ST_SQY:  begin mul_a = 33'(ay_reg);           mul_b = 32'(ay_reg);        end
            ST_CHK:  begin mul_a = 33'(t_reg[21:0]);      mul_b = gmd_pkg::LOG2E_Q30; end
            ST_YST:  begin mul_a = 33'(prod_reg[46:17]);  mul_b = gmd_pkg::LN2_Q32;   end
            ST_TMUL: begin mul_a = term_reg;              mul_b = u_reg;              end
            ST_SQV:  begin mul_a = 33'(vx_reg);           mul_b = 32'(vy_reg);        end
            ST_EMUL: begin mul_a = e_val;                 mul_b = gmd_pkg::INV2PI_Q32; end
            default: begin mul_a = '0;                    mul_b = '0;                 end
        endcase
    end

    // shared divider request select
    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (state_reg)
            ST_DXGO:
            begin
                div_start = 1'b1;
                div_num   = {prod_reg[31:0], 8'd0};
                div_den   = gmd_pkg::DIV_DW'(vx_reg);
            end
            ST_DYGO:
            begin
                div_start = 1'b1;
                div_num   = {prod_reg[31:0], 8'd0};
                div_den   = gmd_pkg::DIV_DW'(vy_reg);
            end
            ST_TDIV:
            begin
                div_start = 1'b1;
                div_num   = gmd_pkg::DIV_NW'(prod_reg[64:32]);
                div_den   = gmd_pkg::DIV_DW'(j_reg);
            end
            ST_FDIV:
            begin
                // floor(P / (s << 24)) == floor((P >> 24) / s)
                div_start = 1'b1;
                div_num   = gmd_pkg::DIV_NW'(prod_reg[62:24]);
                div_den   = gmd_pkg::DIV_DW'(s_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    assign sqrt_start = (state_reg == ST_SQGO);

    gmd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    gmd_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand ({prod_reg[31:0], 16'd0}),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    always_ff @(posedge clk)
    begin
        prod_reg <= 65'(mul_a) * 65'(mul_b);
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            kmax_reg      <= KW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // the done state handles its own handoff
            if (out_valid_reg && out_ch.ready && state_reg != ST_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        k_reg     <= '0;
                        kmax_reg  <= KW'(count_clamp);
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD:  state_reg <= ST_SQX;
                ST_SQX:   state_reg <= ST_DXGO;
                ST_DXGO:  state_reg <= ST_DXW;
                ST_DXW:   if (div_done) state_reg <= ST_SQY;
                ST_SQY:   state_reg <= ST_DYGO;
                ST_DYGO:  state_reg <= ST_DYW;
                ST_DYW:   if (div_done) state_reg <= ST_CHK;
                ST_CHK:   state_reg <= (t_reg >= gmd_pkg::EXP_LIMIT) ? ST_NEXT : ST_YST;
                ST_YST:   state_reg <= ST_USET;
                ST_USET:  state_reg <= ST_TMUL;
                ST_TMUL:  state_reg <= ST_TDIV;
                ST_TDIV:  state_reg <= ST_TW;
                ST_TW:
                begin
                    if (div_done)
                    begin
                        state_reg <= (j_reg == 4'(gmd_pkg::TAYLOR_TERMS)) ? ST_SQV : ST_TMUL;
                    end
                end
                ST_SQV:   state_reg <= ST_SQGO;
                ST_SQGO:  state_reg <= ST_SQW;
                ST_SQW:   if (sqrt_done) state_reg <= ST_EMUL;
                ST_EMUL:  state_reg <= ST_FDIV;
                ST_FDIV:  state_reg <= ST_FW;
                ST_FW:    if (div_done) state_reg <= ST_NEXT;
                ST_NEXT:
                begin
                    if (k_reg + KW'(1) == kmax_reg)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        k_reg     <= k_reg + KW'(1);
                        state_reg <= ST_LOAD;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                x_reg   <= in_ch.pos_x;
                y_reg   <= in_ch.pos_y;
                acc_reg <= '0;
            end
            ST_LOAD:
            begin
                vx_reg <= (comp_sel.var_x == 16'd0) ? 16'd1 : comp_sel.var_x;
                vy_reg <= (comp_sel.var_y == 16'd0) ? 16'd1 : comp_sel.var_y;
                ax_reg <= adx[15:0];
                ay_reg <= ady[15:0];
            end
            ST_DXW:   if (div_done) t_reg <= 41'(div_quo);
            ST_DYW:   if (div_done) t_reg <= t_reg + 41'(div_quo);
            ST_YST:   n_reg <= prod_reg[52:47];
            ST_USET:
            begin
                u_reg    <= prod_reg[61:30];
                term_reg <= 33'h1_0000_0000;
                esum_reg <= 33'h1_0000_0000;
                j_reg    <= 4'd1;
            end
            ST_TW:
            begin
                if (div_done)
                begin
                    term_reg <= tq;
                    esum_reg <= j_reg[0] ? (esum_reg - tq) : (esum_reg + tq);
                    j_reg    <= j_reg + 4'd1;
                end
            end
            ST_SQW:   if (sqrt_done) s_reg <= sqrt_root;
            ST_FW:    if (div_done) acc_reg <= acc_reg + 34'(div_quo);
            ST_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    density_reg <= (|acc_reg[33:32]) ? 32'hFFFF_FFFF : acc_reg[31:0];
                end
            end
            default:
            begin
                term_reg <= term_reg;
            end
        endcase
    end

    assign in_ch.ready    = (state_reg == ST_IDLE);
    assign out_ch.valid   = out_valid_reg;
    assign out_ch.density = density_reg;
endmodule

// ===== rtl/gmd_checker.sv =====
// Port-level checks for the Gaussian mixture density block, bound to the top level.
module gmd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] density,
    input logic        pready
);
    // a request occupies the block: no second request right after
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken on consecutive cycles");

    // a result never appears the cycle after a request
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result too early");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(density))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");
endmodule

bind gaussian_mixture_density_2d_top gmd_checker u_gmd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .density   (out_ch.density),
    .pready    (pready)
);

// ===== tb/gaussian_mixture_density_2d_top_test.sv =====
// Self-checking testbench for the Gaussian mixture density block: directed and random points.
module gaussian_mixture_density_2d_top_test;
    import gmd_pkg::*;

    localparam int MAX_COMP    = 4;
    localparam int CYCLE_LIMIT = 8000000;
    localparam int SETTLE      = 3000;

    class density_board;
        comp_t       comps[NUM_COMP_REGS];
        logic [2:0]  n_use;
        logic [31:0] density_q[$];
        int          errors;
        int          matched;
        int          points;

        function new();
            errors  = 0;
            matched = 0;
            points  = 0;
            for (int k = 0; k < NUM_COMP_REGS; k++)
                comps[k] = COMP_RESET;
            n_use = 1;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] value);
            if (idx < NUM_COMP_REGS)
                comps[idx] = value;
            else if (idx == REG_COUNT)
                n_use = value[2:0];
        endfunction

        function logic [63:0] int_sqrt(logic [63:0] v);
            logic [63:0] res;
            logic [63:0] bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > v)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (v >= res + bitv)
                begin
                    v   = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        // exp(-t / 2^17) in Q.32 via 2^-y, fraction by a Taylor series
        function logic [63:0] exp_neg(logic [63:0] t);
            logic [63:0] y;
            logic [63:0] n;
            logic [63:0] f;
            logic [63:0] u;
            logic [63:0] acc;
            logic [63:0] step;
            y    = (t * 64'(LOG2E_Q30)) >> 17;
            n    = y >> 30;
            f    = {34'd0, y[29:0]};
            u    = (f * 64'(LN2_Q32)) >> 30;
            acc  = 64'd1 << 32;
            step = 64'd1 << 32;
            for (int j = 1; j <= TAYLOR_TERMS; j++)
            begin
                step = ((step * u) >> 32) / 64'(j);
                if (j % 2 == 1)
                    acc = acc - step;
                else
                    acc = acc + step;
            end
            return (n >= 63) ? 64'd0 : (acc >> n);
        endfunction

        function logic [63:0] comp_density(comp_t c, longint x, longint y);
            longint      dx;
            longint      dy;
            logic [63:0] ax;
            logic [63:0] ay;
            logic [63:0] vx;
            logic [63:0] vy;
            logic [63:0] t;
            logic [63:0] s;
            vx = (c.var_x == 0) ? 64'd1 : 64'(c.var_x);
            vy = (c.var_y == 0) ? 64'd1 : 64'(c.var_y);
            dx = x - longint'(c.mean_x);
            dy = y - longint'(c.mean_y);
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            t  = (((ax * ax) << 8) / vx) + (((ay * ay) << 8) / vy);
            if (t >= 64'(EXP_LIMIT))
                return 0;
            s = int_sqrt((vx * vy) << 16);
            return (64'(INV2PI_Q32) * exp_neg(t)) / (s << 24);
        endfunction

        function logic [31:0] mixture(logic signed [15:0] px, logic signed [15:0] py);
            int          count;
            logic [63:0] total;
            count = n_use;
            total = 0;
            if (count == 0)
                count = 1;
            if (count > MAX_COMP)
                count = MAX_COMP;
            for (int k = 0; k < count; k++)
                total = total + comp_density(comps[k], longint'(px), longint'(py));
            return (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
        endfunction

        function void note_point(logic signed [15:0] px, logic signed [15:0] py);
            density_q.push_back(mixture(px, py));
            points++;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_density(logic [31:0] got);
            logic [31:0] want;
            if (density_q.size() == 0)
                report($sformatf("density 0x%08h with no point pending", got));
            else
            begin
                want = density_q.pop_front();
                if (got !== want)
                    report($sformatf("density 0x%08h, predicted 0x%08h", got, want));
                else
                    matched++;
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    int          cycles;
    int          idle_pct;
    int          stall_pct;
    int          reg_writes;
    density_board board;

    gmd_in_if  in_ch ();
    gmd_out_if out_ch ();

    gaussian_mixture_density_2d_top #(
        .MAX_COMPONENTS (MAX_COMP)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles", cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // density sink with random back-pressure
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
                board.check_density(out_ch.density);
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task write_reg(logic [2:0] idx, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        board.write_reg(idx, value);
        reg_writes++;
        // idle the bus before the next request
        @(posedge clk);
    endtask

    task send_point(logic signed [15:0] px, logic signed [15:0] py);
        while ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.pos_x <= px;
        in_ch.pos_y <= py;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        board.note_point(px, py);
    endtask

    task drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.density_q.size() != 0)
            @(posedge clk);
    endtask

    function logic [15:0] pick_var();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return 16'd0;
        if (r < 14)
            return 16'hFFFF;
        if (r < 24)
            return 16'($urandom);
        return 16'($urandom_range(16, 2048));
    endfunction

    task random_config();
        comp_t c;
        int    r;
        drain();
        for (int k = 0; k < NUM_COMP_REGS; k++)
        begin
            c.mean_x = 16'($urandom);
            c.mean_y = 16'($urandom);
            c.var_x  = pick_var();
            c.var_y  = pick_var();
            write_reg(REG_COMP_0 + 3'(k), c);
        end
        r = $urandom_range(99);
        // mostly legal counts, sometimes zero or above the maximum
        write_reg(REG_COUNT, (r < 85) ? 64'($urandom_range(1, 4)) : 64'($urandom_range(0, 7)));
    endtask

    task random_point();
        int          count;
        int          k;
        int          span;
        logic [15:0] px;
        logic [15:0] py;
        count = (board.n_use == 0) ? 1 : ((board.n_use > MAX_COMP) ? MAX_COMP : board.n_use);
        if ($urandom_range(99) < 70)
        begin
            // land near a component mean so the exponent is usually in range
            k    = $urandom_range(count - 1);
            span = $urandom_range(8, 1024);
            px   = board.comps[k].mean_x + 16'($urandom_range(0, 2 * span) - span);
            py   = board.comps[k].mean_y + 16'($urandom_range(0, 2 * span) - span);
        end
        else
        begin
            px = 16'($urandom);
            py = 16'($urandom);
        end
        send_point(px, py);
    endtask

    initial
    begin
        int phase_idle[4];
        int phase_stall[4];
        board       = new();
        rst_n       = 1'b0;
        reg_writes  = 0;
        idle_pct    = 0;
        stall_pct   = 0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        in_ch.valid <= 1'b0;
        in_ch.pos_x <= '0;
        in_ch.pos_y <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: one unit Gaussian at the origin
        send_point(16'sh0000, 16'sh0000);
        send_point(16'sh7FFF, 16'sh7FFF);
        send_point(-16'sh8000, -16'sh8000);
        send_point(-16'sh8000, 16'sh7FFF);
        send_point(16'sh0100, -16'sh0080);
        // exponent right below and at its cutoff
        send_point(16'sh07FF, 16'sh0000);
        send_point(16'sh0800, 16'sh0000);
        drain();

        // zero variances, extreme means, all components, count of zero
        write_reg(REG_COMP_0, 64'h0000_0000_0000_0000);
        write_reg(REG_COMP_0 + 3'd1, 64'hFFFF_FFFF_8000_8000);
        write_reg(REG_COMP_0 + 3'd2, 64'h0100_0000_7FFF_7FFF);
        write_reg(REG_COMP_0 + 3'd3, 64'h0001_FFFF_FFFF_0001);
        write_reg(REG_COUNT, 64'd0);
        send_point(16'sh0000, 16'sh0000);
        send_point(16'sh0001, 16'sh0000);
        drain();
        write_reg(REG_COUNT, 64'd4);
        send_point(-16'sh8000, -16'sh8000);
        send_point(16'sh7FFF, 16'sh7FFF);
        send_point(16'sh7FFF, -16'sh8000);
        send_point(-16'sh0001, 16'sh0001);
        send_point(16'sh0000, 16'sh0000);
        drain();
        // count above the maximum, components stacked on one mean
        for (int k = 0; k < NUM_COMP_REGS; k++)
            write_reg(REG_COMP_0 + 3'(k), 64'h0001_0001_0000_0000);
        write_reg(REG_COUNT, 64'd7);
        send_point(16'sh0000, 16'sh0000);
        send_point(16'sh0000, 16'sh0001);
        drain();
        write_reg(REG_COUNT, 64'd5);
        send_point(16'sh0000, 16'sh0000);
        send_point(16'sh5555, -16'sh5556);

        phase_idle  = '{0, 74, 0, 26};
        phase_stall = '{0, 0, 74, 26};
        for (int p = 0; p < 4; p++)
        begin
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            for (int i = 0; i < 136; i++)
            begin
                if (i % 34 == 0)
                    random_config();
                // hold the stream until every density is back
                if (i == 17)
                    drain();
                random_point();
            end
        end
        idle_pct  = 0;
        stall_pct = 0;
        drain();
        repeat (SETTLE) @(posedge clk);

        $display("Sent %0d points over %0d register writes; %0d densities matched.",
                 board.points, reg_writes, board.matched);
        $display("Idle and back-pressure phases covered; %0d mismatches.", board.errors);
        if (board.errors == 0 && board.density_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
